// ----- rtl/dns_question_section_parser_macros.svh -----
// assertion macros for the dns question section parser
// included by the rtl files that carry concurrent checks
`ifndef DNS_QUESTION_SECTION_PARSER_MACROS_SVH
`define DNS_QUESTION_SECTION_PARSER_MACROS_SVH

// consequent checked in the same cycle
`define DNSQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define DNSQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dnsq_pkg.sv -----
// shared types and constants for the dns question section parser
// no dependencies
package dnsq_pkg;

    localparam int MAX_LABEL_LEN_DEF = 63;
    localparam int MAX_NAME_POS_DEF  = 255;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [15:0] MSG_HEADER_LEN = 16'd12;
    localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;
    localparam logic [15:0] OFFSET_LIMIT   = OFFSET_MAX - MSG_HEADER_LEN;
    localparam logic [8:0]  TAIL_LEN       = 9'd5;
    localparam logic [7:0]  DOT_CHAR       = 8'h2E;
    localparam logic [1:0]  TAIL_LAST      = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_NAME,
        PH_TAIL
    } dnsq_phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        section_start;
        logic [15:0] question_count;
        logic        section_end;
    } dnsq_in_t;

    typedef struct packed {
        logic [7:0]  name_char;
        logic        char_valid;
        logic        question_done;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [8:0]  question_bytes;
        logic [15:0] name_offset;
        logic        section_done;
        logic        status;
    } dnsq_out_t;

    // input word plus front-end classification
    typedef struct packed {
        dnsq_in_t word;
        logic     len_zero;
        logic     len_over;
    } dnsq_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dnsq_q_status_t;

endpackage

// ----- rtl/dnsq_front.sv -----
// front end: accepts input words and classifies the byte as a label length
// depends on dnsq_pkg
module dnsq_front #(
    parameter int MAX_LABEL_LEN = dnsq_pkg::MAX_LABEL_LEN_DEF
) (
    input  logic                    s_valid,
    output logic                    s_ready,
    input  dnsq_pkg::dnsq_in_t      s_data,
    input  dnsq_pkg::dnsq_q_status_t q_status,
    output logic                    q_push,
    output dnsq_pkg::dnsq_entry_t   q_entry
);
    import dnsq_pkg::*;

    assign s_ready = !q_status.full;
    assign q_push  = s_valid && !q_status.full;

    always_comb begin
        q_entry.word     = s_data;
        q_entry.len_zero = (s_data.data_byte == 8'd0);
        q_entry.len_over = (s_data.data_byte > 8'(MAX_LABEL_LEN));
    end

endmodule

// ----- rtl/dnsq_queue.sv -----
// short queue between front end and parser back end
// depends on dnsq_pkg and the assertion macro header
`include "dns_question_section_parser_macros.svh"

module dnsq_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  dnsq_pkg::dnsq_entry_t    push_entry,
    input  logic                     pop,
    output dnsq_pkg::dnsq_entry_t    head_entry,
    output dnsq_pkg::dnsq_q_status_t status
);
    import dnsq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dnsq_entry_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry   = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    `DNSQ_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `DNSQ_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not rise on push")
    `DNSQ_ASSERT_NEXT(a_count_down, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - 1'b1, "queue count did not fall on pop")

endmodule

// ----- rtl/dnsq_back.sv -----
// back end: question section parser state and output register
// depends on dnsq_pkg and the assertion macro header
`include "dns_question_section_parser_macros.svh"

module dnsq_back #(
    parameter int MAX_NAME_POS = dnsq_pkg::MAX_NAME_POS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dnsq_pkg::dnsq_entry_t    head_entry,
    input  dnsq_pkg::dnsq_q_status_t q_status,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output dnsq_pkg::dnsq_out_t      m_data
);
    import dnsq_pkg::*;

    dnsq_phase_t phase_reg, phase_next;
    logic [5:0]  label_left_reg, label_left_next;
    logic [8:0]  name_pos_reg, name_pos_next;
    logic [1:0]  tail_idx_reg, tail_idx_next;
    logic [23:0] shift_reg, shift_next;
    logic [15:0] q_left_reg, q_left_next;
    logic [15:0] sec_off_reg, sec_off_next;
    logic [15:0] q_start_reg, q_start_next;
    logic        first_reg, first_next;
    logic        m_valid_reg;
    dnsq_out_t   m_data_reg, result;

    assign q_pop = !q_status.empty && (!m_valid_reg || m_ready);

    always_comb begin
        logic [7:0] b;
        logic       active;
        logic       bad;
        logic       done;

        b             = head_entry.word.data_byte;
        phase_next    = phase_reg;
        label_left_next = label_left_reg;
        name_pos_next = name_pos_reg;
        tail_idx_next = tail_idx_reg;
        shift_next    = shift_reg;
        q_left_next   = q_left_reg;
        sec_off_next  = sec_off_reg;
        q_start_next  = q_start_reg;
        first_next    = first_reg;
        result        = '0;
        bad           = 1'b0;
        done          = 1'b0;

        // section start restarts everything on this word
        if (head_entry.word.section_start) begin
            q_left_next     = head_entry.word.question_count;
            sec_off_next    = '0;
            q_start_next    = '0;
            phase_next      = PH_NAME;
            first_next      = 1'b1;
            label_left_next = '0;
            name_pos_next   = '0;
            tail_idx_next   = '0;
            shift_next      = '0;
        end
        active = (phase_next != PH_IDLE);

        case (phase_next)
            PH_NAME: begin
                if (label_left_next != '0) begin
                    result.name_char  = b;
                    result.char_valid = 1'b1;
                    label_left_next   = label_left_next - 1'b1;
                    name_pos_next     = name_pos_next + 1'b1;
                end else begin
                    if (first_next) begin
                        if (q_left_next == '0 || sec_off_next > OFFSET_LIMIT) begin
                            bad = 1'b1;
                        end else begin
                            q_start_next = sec_off_next;
                        end
                    end else if (name_pos_next == '0 ||
                                 (name_pos_next - 1'b1) > 9'(MAX_NAME_POS)) begin
                        bad = 1'b1;
                    end
                    if (head_entry.len_over) begin
                        bad = 1'b1;
                    end
                    if (!bad) begin
                        if (head_entry.len_zero) begin
                            phase_next    = PH_TAIL;
                            tail_idx_next = '0;
                            shift_next    = '0;
                        end else begin
                            if (!first_next) begin
                                result.name_char  = DOT_CHAR;
                                result.char_valid = 1'b1;
                            end
                            label_left_next = b[5:0];
                            name_pos_next   = name_pos_next + 1'b1;
                        end
                        first_next = 1'b0;
                    end
                end
            end
            PH_TAIL: begin
                if (tail_idx_next == TAIL_LAST) begin
                    done                  = 1'b1;
                    result.question_done  = 1'b1;
                    result.record_type    = shift_next[23:8];
                    result.record_class   = {shift_next[7:0], b};
                    result.question_bytes = name_pos_next + TAIL_LEN;
                    result.name_offset    = q_start_next + MSG_HEADER_LEN;
                    q_left_next           = q_left_next - 1'b1;
                    phase_next            = PH_NAME;
                    first_next            = 1'b1;
                    label_left_next       = '0;
                    name_pos_next         = '0;
                    tail_idx_next         = '0;
                    shift_next            = '0;
                end else begin
                    shift_next    = {shift_next[15:0], b};
                    tail_idx_next = tail_idx_next + 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (active && sec_off_next != OFFSET_MAX) begin
            sec_off_next = sec_off_next + 1'b1;
        end

        if (bad) begin
            result.name_char    = '0;
            result.char_valid   = 1'b0;
            result.section_done = 1'b1;
            result.status       = 1'b1;
            phase_next          = PH_IDLE;
        end else if (active && head_entry.word.section_end) begin
            result.section_done = 1'b1;
            result.status       = !(done && q_left_next == '0);
            phase_next          = PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            label_left_reg <= '0;
            name_pos_reg   <= '0;
            tail_idx_reg   <= '0;
            shift_reg      <= '0;
            q_left_reg     <= '0;
            sec_off_reg    <= '0;
            q_start_reg    <= '0;
            first_reg      <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg      <= phase_next;
                label_left_reg <= label_left_next;
                name_pos_reg   <= name_pos_next;
                tail_idx_reg   <= tail_idx_next;
                shift_reg      <= shift_next;
                q_left_reg     <= q_left_next;
                sec_off_reg    <= sec_off_next;
                q_start_reg    <= q_start_next;
                first_reg      <= first_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `DNSQ_ASSERT_SAME(a_status_with_done, aclk, aresetn, m_valid_reg && m_data_reg.status, m_data_reg.section_done, "status without section done")
    `DNSQ_ASSERT_SAME(a_question_no_char, aclk, aresetn, m_valid_reg && m_data_reg.question_done, !m_data_reg.char_valid, "question done with a name character")
    `DNSQ_ASSERT_SAME(a_tail_no_label, aclk, aresetn, phase_reg == PH_TAIL, label_left_reg == '0 && !first_reg, "tail phase with label bytes pending")

endmodule

// ----- rtl/dns_question_section_parser.sv -----
// dns question section parser top level: front end, word queue, parser back end
// depends on dnsq_pkg, dnsq_front, dnsq_queue and dnsq_back
//
// Takes one byte of a dns question section per word and returns exactly one result
// word per input word, in order. Sustained rate is one word per clock on both sides
// while m_ready is held high. With the queue empty and the output free, a taken input
// word is first written into the four-word queue and is then parsed into the output
// register. The queue lets the input keep flowing while the output is stalled, and
// s_ready drops only once the queue holds four words. Bad sections report
// section_done with status 1 and are ignored up to the next section_start word.
module dns_question_section_parser #(
    parameter int MAX_LABEL_LEN = dnsq_pkg::MAX_LABEL_LEN_DEF,
    parameter int MAX_NAME_POS  = dnsq_pkg::MAX_NAME_POS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dnsq_pkg::dnsq_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dnsq_pkg::dnsq_out_t m_data
);
    import dnsq_pkg::*;

    dnsq_q_status_t q_status;
    dnsq_entry_t    push_entry;
    dnsq_entry_t    head_entry;
    logic           q_push;
    logic           q_pop;

    dnsq_front #(
        .MAX_LABEL_LEN (MAX_LABEL_LEN)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    dnsq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    dnsq_back #(
        .MAX_NAME_POS (MAX_NAME_POS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
